@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and types for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ORDER_COUNT = 11;
    localparam int PAGE_BITS   = 12;
    localparam int NUM_PAGES   = 32768;
    localparam int ADDR_W      = 27;
    localparam int SIZE_W      = 32;
    localparam int ORD_W       = $clog2(ORDER_COUNT + 1);
    localparam int WPO         = (NUM_PAGES >> 5) + 1;
    localparam int WIDX_W      = $clog2(WPO);
    localparam int RAM_DEPTH   = ORDER_COUNT * (1 << WIDX_W);
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int CNT_W       = 16;
    localparam int BLK_W       = $clog2(NUM_PAGES) + 1;
    localparam int CLR_W       = RAM_AW + 1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_TAKE_WR, S_SPLIT_RD,
        S_SPLIT_WR, S_FREE_RD, S_FREE_CHK, S_FREE_WR, S_RESP
    } state_t;

    typedef struct packed {
        logic load;       // capture request
        logic clr_wr;     // clearing pass write
        logic rd;         // issue RAM read at current (order, word)
        logic scan_next;  // advance scan word / order
        logic take;       // clear found bit, latch block number
        logic split_down; // go one order lower, block <<= 1
        logic set_buddy;  // write buddy bit set (split)
        logic merge_clr;  // clear buddy bit, merge up
        logic put_self;   // set own bit (free end)
        logic set_fail;
        logic set_ign;
        logic set_done;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic too_big;
        logic free_bad;
        logic word_hit;   // scanned word nonzero
        logic scan_end;   // last word of last order
        logic at_want;
        logic buddy_free;
        logic at_top;
    } stat_t;

endpackage

@@ rtl/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, alloc scan/split and free merge.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_fire,
    input  logic   out_fire,
    input  stat_t  st,
    output ctrl_t  cmd,
    output logic   s_ready,
    output logic   m_valid
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (st.clr_last) state_next = S_IDLE;
            S_IDLE:     if (in_fire) state_next = S_SCAN_RD;
            S_SCAN_RD: begin
                if (st.is_alloc) begin
                    state_next = st.too_big ? S_RESP : S_SCAN_CHK;
                end else begin
                    state_next = st.free_bad ? S_RESP : S_FREE_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (st.word_hit)      state_next = S_TAKE_WR;
                else if (st.scan_end) state_next = S_RESP;
                else                  state_next = S_SCAN_CHK;
            end
            S_TAKE_WR:  state_next = st.at_want ? S_RESP : S_SPLIT_RD;
            S_SPLIT_RD: state_next = S_SPLIT_WR;
            S_SPLIT_WR: state_next = st.at_want ? S_RESP : S_SPLIT_RD;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK: begin
                if (st.buddy_free && !st.at_top) state_next = S_FREE_RD;
                else                             state_next = S_FREE_WR;
            end
            S_FREE_WR:  state_next = S_RESP;
            S_RESP:     if (out_fire) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_RESP);
        case (state_reg)
            S_CLEAR:    cmd.clr_wr = 1'b1;
            S_IDLE:     cmd.load = in_fire;
            S_SCAN_RD: begin
                if (st.is_alloc && st.too_big)   cmd.set_fail = 1'b1;
                if (!st.is_alloc && st.free_bad) cmd.set_ign = 1'b1;
                if (!(st.is_alloc ? st.too_big : st.free_bad)) cmd.rd = 1'b1;
            end
            S_SCAN_CHK: begin
                if (st.word_hit) begin
                    cmd.take = 1'b1;
                end else if (st.scan_end) begin
                    cmd.set_fail = 1'b1;
                end else begin
                    cmd.scan_next = 1'b1;
                    cmd.rd = 1'b1;
                end
            end
            S_TAKE_WR: begin
                if (st.at_want) cmd.set_done = 1'b1;
                else            cmd.split_down = 1'b1;
            end
            S_SPLIT_RD: cmd.rd = 1'b1;
            S_SPLIT_WR: begin
                cmd.set_buddy = 1'b1;
                if (st.at_want) cmd.set_done = 1'b1;
                else            cmd.split_down = 1'b1;
            end
            S_FREE_RD:  cmd.rd = 1'b1;
            S_FREE_CHK: begin
                if (st.buddy_free && !st.at_top) begin
                    cmd.merge_clr = 1'b1;
                end else begin
                    cmd.rd = 1'b1;
                end
            end
            S_FREE_WR: begin
                cmd.put_self = 1'b1;
                cmd.set_done = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/bpa_dp.sv @@
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: request registers, bitmap RAM, free counts, scan and merge logic.
// ----------------------------------------------------------------------------
module bpa_dp
    import bpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_t               cmd,
    input  logic                s_op,
    input  logic [SIZE_W-1:0]   s_size_bytes,
    input  logic [ADDR_W-1:0]   s_block_addr,
    output stat_t               st,
    output logic [ADDR_W-1:0]   m_granted_addr,
    output logic [1:0]          m_status
);
    logic                op_reg;
    logic [ORD_W-1:0]    want_reg;
    logic                bad_reg;
    logic [ORD_W-1:0]    ord_reg, ord_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [WIDX_W-1:0]   wrd_reg, wrd_next;
    logic [CLR_W-1:0]    clr_reg;
    logic [ADDR_W-1:0]   gaddr_reg;
    logic [1:0]          status_reg;
    logic [CNT_W-1:0]    cnt_reg [ORDER_COUNT];

    logic [ORD_W-1:0]    want_c;
    logic [BLK_W-1:0]    tgt_blk;
    logic [BLK_W-1:0]    buddy;
    logic                tgt_oob;
    logic [WIDX_W-1:0]   ram_wrd;
    logic [RAM_AW-1:0]   ram_addr;
    logic                ram_we;
    logic [31:0]         ram_wdata, ram_rdata;
    logic [4:0]          lsb;
    logic                do_write;
    logic [4:0]          bitpos;
    logic                bitval;
    logic [ORD_W-1:0]    cnt_ord;
    logic                cnt_inc, cnt_dec;

    // size to order: compare against each order's byte span
    always_comb begin
        want_c = ORD_W'(ORDER_COUNT);
        for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            if ({1'b0, s_size_bytes} <= (33'd1 << (PAGE_BITS + k))) begin
                want_c = ORD_W'(k);
            end
        end
    end

    always_comb begin
        lsb = '0;
        for (int b = 31; b >= 0; b--) begin
            if (ram_rdata[b]) lsb = 5'(b);
        end
    end

    // target block: buddy in merge, own block when writing back
    always_comb begin
        buddy = blk_reg ^ BLK_W'(1);
        tgt_blk = (cmd.put_self) ? blk_reg : buddy;
        tgt_oob = ({1'b0, tgt_blk[BLK_W-1:5]} >= (BLK_W - 4)'(WPO));
    end

    always_comb begin
        do_write = 1'b0;
        bitpos = tgt_blk[4:0];
        bitval = 1'b0;
        ram_wrd = tgt_blk[5+WIDX_W-1:5];
        if (cmd.clr_wr) begin
            ram_wrd = '0;
        end else if (cmd.take) begin
            ram_wrd = wrd_reg;
            bitpos = lsb;
            do_write = 1'b1;
        end else if (cmd.scan_next || (op_reg == OP_ALLOC && !cmd.set_buddy)) begin
            ram_wrd = wrd_next;
        end
        if (cmd.set_buddy || cmd.merge_clr || cmd.put_self) begin
            do_write = !tgt_oob;
            bitval = cmd.set_buddy || cmd.put_self;
        end
        if (cmd.rd && op_reg != OP_ALLOC && !cmd.put_self) begin
            ram_wrd = cmd.merge_clr ? buddy[5+WIDX_W-1:5] : tgt_blk[5+WIDX_W-1:5];
        end
    end

    always_comb begin
        ram_addr = RAM_AW'(ord_next) * RAM_AW'(1 << WIDX_W) + RAM_AW'(ram_wrd);
        if (cmd.clr_wr) ram_addr = clr_reg[RAM_AW-1:0];
        if (do_write) ram_addr = RAM_AW'(ord_reg) * RAM_AW'(1 << WIDX_W)
                               + RAM_AW'(cmd.take ? wrd_reg : tgt_blk[5+WIDX_W-1:5]);
        ram_we = cmd.clr_wr || do_write;
        ram_wdata = '0;
        if (do_write) begin
            ram_wdata = ram_rdata;
            ram_wdata[bitpos] = bitval;
        end
    end

    bpa_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        ord_next = ord_reg;
        wrd_next = wrd_reg;
        blk_next = blk_reg;
        if (cmd.load) begin
            ord_next = want_c;
            wrd_next = '0;
            blk_next = BLK_W'({1'b0, s_block_addr} >> (PAGE_BITS + 32'(want_c)));
        end else if (cmd.scan_next) begin
            if (wrd_reg == WIDX_W'(WPO - 1)) begin
                wrd_next = '0;
                ord_next = ord_reg + 1'b1;
            end else begin
                wrd_next = wrd_reg + 1'b1;
            end
        end else if (cmd.take) begin
            blk_next = BLK_W'({wrd_reg, lsb});
        end else if (cmd.split_down) begin
            ord_next = ord_reg - 1'b1;
            blk_next = {blk_reg[BLK_W-2:0], 1'b0};
            wrd_next = blk_next[5+WIDX_W-1:5];
        end else if (cmd.merge_clr) begin
            ord_next = ord_reg + 1'b1;
            blk_next = blk_reg >> 1;
        end
    end

    // one count update per cycle
    always_comb begin
        cnt_inc = cmd.set_buddy || cmd.put_self;
        cnt_dec = cmd.take || cmd.merge_clr;
        cnt_ord = ord_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            ord_reg    <= '0;
            wrd_reg    <= '0;
            status_reg <= ST_DONE;
            for (int k = 0; k < ORDER_COUNT; k++) cnt_reg[k] <= '0;
        end else begin
            ord_reg <= ord_next;
            wrd_reg <= wrd_next;
            if (cmd.clr_wr) clr_reg <= clr_reg + 1'b1;
            for (int k = 0; k < ORDER_COUNT; k++) begin
                if (cnt_ord == ORD_W'(k)) begin
                    if (cnt_inc && cnt_reg[k] != '1) cnt_reg[k] <= cnt_reg[k] + 1'b1;
                    if (cnt_dec && cnt_reg[k] != '0) cnt_reg[k] <= cnt_reg[k] - 1'b1;
                end
            end
            if (cmd.set_fail) status_reg <= ST_FAIL;
            if (cmd.set_ign)  status_reg <= ST_IGNORED;
            if (cmd.set_done) status_reg <= ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        if (cmd.load) begin
            op_reg    <= s_op;
            want_reg  <= want_c;
            gaddr_reg <= '0;
            bad_reg   <= (s_block_addr == '0) || (want_c >= ORD_W'(ORDER_COUNT))
                      || ({5'd0, s_block_addr} >= (32'(NUM_PAGES) << PAGE_BITS));
        end
        if (cmd.set_done && op_reg == OP_ALLOC) begin
            gaddr_reg <= ADDR_W'({32'd0, blk_next} << (PAGE_BITS + 32'(want_reg)));
        end
    end

    always_comb begin
        st.clr_last   = (clr_reg == CLR_W'(RAM_DEPTH - 1));
        st.is_alloc   = (op_reg == OP_ALLOC);
        st.too_big    = (want_reg >= ORD_W'(ORDER_COUNT));
        st.free_bad   = bad_reg;
        st.word_hit   = (ram_rdata != '0);
        st.scan_end   = (ord_reg == ORD_W'(ORDER_COUNT - 1)) && (wrd_reg == WIDX_W'(WPO - 1));
        st.at_want    = (ord_reg == want_reg);
        st.buddy_free = !tgt_oob && ram_rdata[buddy[4:0]];
        st.at_top     = (ord_reg == ORD_W'(ORDER_COUNT - 1));
    end

    assign m_granted_addr = gaddr_reg;
    assign m_status       = status_reg;
endmodule

@@ rtl/buddy_page_allocator_core.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Buddy page allocator: bitmap per order, one request at a time.
// ----------------------------------------------------------------------------
// After reset a clearing pass of one RAM word per cycle (ORDER_COUNT * 2^11 =
// 22528 words) runs before the first beat is taken. Requests are served one
// at a time through a single-port bitmap RAM: an alloc scans one bitmap word
// per cycle from its order upward, then splits one level at a time with a read
// and a write per level; a free merges one level at a time with a read and a
// check per level. A rejected request goes straight to the response; an alloc
// may scan every word of every order (1025 words per order) before it answers.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [SIZE_W-1:0] s_size_bytes,
    input  logic [ADDR_W-1:0] s_block_addr,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_granted_addr,
    output logic [1:0]        m_status
);
    ctrl_t cmd;
    stat_t st;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_valid && s_ready),
        .out_fire (m_valid && m_ready),
        .st       (st),
        .cmd      (cmd),
        .s_ready  (s_ready),
        .m_valid  (m_valid)
    );

    bpa_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_op           (s_op),
        .s_size_bytes   (s_size_bytes),
        .s_block_addr   (s_block_addr),
        .st             (st),
        .m_granted_addr (m_granted_addr),
        .m_status       (m_status)
    );
endmodule

@@ tb/buddy_page_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_core_tb
// Self-checking bench for the buddy page allocator. A scoreboard class keeps
// its own per-order free bitmaps, predicts the grant address and status of
// every accepted request, and checks the results in order. The stimulus is a
// directed list of corner cases followed by random alloc/free traffic that is
// mostly confined to low memory, with random idling on both channels.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core_tb;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 200000;
    localparam int RX_HOLD    = 300;
    localparam int N_RANDOM   = 370;

    class alloc_scoreboard;
        typedef struct {
            logic [ADDR_W-1:0] addr;
            logic [1:0]        status;
        } grant_t;

        bit               free_map[ORDER_COUNT][WPO*32];
        logic [CNT_W-1:0] free_cnt[ORDER_COUNT];
        grant_t           pending_q[$];
        int errors, n_grant, n_nofit, n_freed, n_ignored;

        function new();
            foreach (free_cnt[k]) free_cnt[k] = '0;
        endfunction

        function void report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        function int order_of(logic [SIZE_W-1:0] size);
            int k;
            k = 0;
            while (k < ORDER_COUNT && longint'(size) > (longint'(1) << (PAGE_BITS + k)))
                k++;
            return k;
        endfunction

        function int lowest_free(int k);
            for (int n = 0; n < WPO*32; n++)
                if (free_map[k][n]) return n;
            return -1;
        endfunction

        function void bump(int k, bit up);
            if (up && free_cnt[k] != '1) free_cnt[k]++;
            if (!up && free_cnt[k] != '0) free_cnt[k]--;
        endfunction

        function void note_request(logic op, logic [SIZE_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            int want, k, f;
            longint n;
            grant_t g;
            want = order_of(size);
            g.addr = '0;
            if (op == OP_ALLOC) begin
                g.status = ST_FAIL;
                for (int i = want; i < ORDER_COUNT && g.status == ST_FAIL; i++) begin
                    f = lowest_free(i);
                    if (f >= 0) begin
                        n = f;
                        k = i;
                        free_map[k][n] = 0;
                        bump(k, 0);
                        // split down, upper half of each level goes free
                        while (k > want) begin
                            k--;
                            n = n << 1;
                            free_map[k][n ^ 1] = 1;
                            bump(k, 1);
                        end
                        g.addr = ADDR_W'(n << (PAGE_BITS + want));
                        g.status = ST_DONE;
                    end
                end
                if (g.status == ST_DONE) n_grant++; else n_nofit++;
            end else if (addr == '0 || want >= ORDER_COUNT ||
                         longint'(addr) >= (longint'(NUM_PAGES) << PAGE_BITS)) begin
                g.status = ST_IGNORED;
                n_ignored++;
            end else begin
                k = want;
                n = longint'(addr) >> (PAGE_BITS + k);
                while (k + 1 < ORDER_COUNT && free_map[k][n ^ 1]) begin
                    free_map[k][n ^ 1] = 0;
                    bump(k, 0);
                    n = n >> 1;
                    k++;
                end
                free_map[k][n] = 1;
                bump(k, 1);
                g.status = ST_DONE;
                n_freed++;
            end
            pending_q.push_back(g);
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] status);
            grant_t g;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result addr=%h status=%0d", addr, status));
                return;
            end
            g = pending_q.pop_front();
            if (status !== g.status)
                report($sformatf("status %0d, want %0d", status, g.status));
            if (addr !== g.addr)
                report($sformatf("granted_addr %h, want %h", addr, g.addr));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_op;
    logic [SIZE_W-1:0] s_size_bytes;
    logic [ADDR_W-1:0] s_block_addr;
    logic              m_valid;
    logic              m_ready;
    logic [ADDR_W-1:0] m_granted_addr;
    logic [1:0]        m_status;

    alloc_scoreboard sb = new();
    bit rx_hold;
    bit calm;
    int idle_cycles = 0;

    buddy_page_allocator_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_size_bytes  (s_size_bytes),
        .s_block_addr  (s_block_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted_addr(m_granted_addr),
        .m_status      (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task send(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op         = op;
        s_size_bytes = size;
        s_block_addr = addr;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, size, addr);
        @(negedge aclk);
    endtask

    function int pick_order();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(0, ORDER_COUNT - 1);
    endfunction

    function logic [SIZE_W-1:0] size_for(int k);
        longint lo, hi;
        hi = longint'(1) << (PAGE_BITS + k);
        lo = (k == 0) ? 0 : (hi >> 1) + 1;
        return SIZE_W'(($urandom_range(0, 2) == 0) ? hi : $urandom_range(hi, lo));
    endfunction

    task send_random();
        int k, hi;
        longint n;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        k = pick_order();
        size = size_for(k);
        if ($urandom_range(0, 99) < 3) size = $urandom | 32'h0040_0001;
        if ($urandom_range(0, 9) < 6) begin
            hi = (k < 9) ? (511 >> k) : ((NUM_PAGES >> k) - 1);
            n = $urandom_range(0, hi);
            addr = ADDR_W'(n << (PAGE_BITS + k));
            if ($urandom_range(0, 3) == 0)
                addr |= ADDR_W'($urandom) & ADDR_W'((longint'(1) << (PAGE_BITS + k)) - 1);
            if ($urandom_range(0, 9) == 0) addr = ADDR_W'($urandom);
            if ($urandom_range(0, 49) == 0) addr = '0;
            send(OP_FREE, size, addr);
        end else begin
            send(OP_ALLOC, size, ADDR_W'($urandom));
        end
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready = 1'b0;
                repeat (RX_HOLD) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (calm) begin
                m_ready = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
            end else begin
                m_ready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_result(m_granted_addr, m_status);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_ALLOC;
        s_size_bytes = '0;
        s_block_addr = '0;
        rx_hold      = 1'b0;
        calm         = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // corner cases, starting from an all-allocated memory
        send(OP_ALLOC, 32'd4096,       '0);          // nothing free yet
        send(OP_ALLOC, 32'hFFFF_FFFF,  '1);          // too large
        send(OP_FREE,  32'd4096,       '0);          // free of address zero
        send(OP_FREE,  32'h0040_0001,  27'h1000);    // free size too large
        send(OP_FREE,  32'd0,          27'h1000);    // size zero = one page
        send(OP_FREE,  32'd8192,       27'h2000);
        send(OP_FREE,  32'd16384,      27'h4123);    // unaligned
        send(OP_FREE,  32'd1,          27'h1000);    // double free
        send(OP_ALLOC, 32'd0,          '0);
        send(OP_ALLOC, 32'd5000,       '0);
        send(OP_FREE,  32'h0040_0000,  27'h7C0_0000); // top order, last block
        send(OP_FREE,  32'd4096,       27'h7FF_FFFF); // last page, unaligned
        send(OP_ALLOC, 32'h0040_0000,  '0);
        send(OP_FREE,  32'h0040_0000,  27'h040_0000);
        send(OP_ALLOC, 32'h0040_0001,  '0);
        send(OP_ALLOC, 32'd4097,       '0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 50) calm = ~calm;
            if (i == 150) begin
                // receiver stalls long while requests keep coming
                rx_hold = 1'b1;
                repeat (8) send(OP_FREE, size_for(0),
                                ADDR_W'($urandom_range(1, 511)) << PAGE_BITS);
            end
            if (i == 250) begin
                s_valid = 1'b0;
                while (sb.pending_q.size() != 0) @(negedge aclk);
            end
            send_random();
        end
        s_valid = 1'b0;

        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);

        $display("allocs granted %0d, refused %0d; frees done %0d, ignored %0d",
                 sb.n_grant, sb.n_nofit, sb.n_freed, sb.n_ignored);
        $display("mismatches %0d", sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
